### rtl/queue_with_positional_insert_macros.svh
// Assertion macros used by the checker file of the queue.
`ifndef QUEUE_WITH_POSITIONAL_INSERT_MACROS_SVH
`define QUEUE_WITH_POSITIONAL_INSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QWPI_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define QWPI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/qwpi_pkg.sv
package qwpi_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned OpW = 2;
  localparam int unsigned PosW = 5;
  localparam int unsigned StatusW = 2;
  localparam int unsigned OccW = 5;
  localparam int unsigned DefaultDepth = 16;

  // Packed widths of the stream payloads, rounded up to whole bytes.
  localparam int unsigned InFieldsW = OpW + DataW + PosW;
  localparam int unsigned OutFieldsW = DataW + StatusW + OccW;
  localparam int unsigned InTdataW = ((InFieldsW + 7) / 8) * 8;
  localparam int unsigned OutTdataW = ((OutFieldsW + 7) / 8) * 8;

  typedef enum logic [OpW-1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_INSERT  = 2'd2
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // Broadcast to every cell of the chain for one transfer.
  typedef struct packed {
    logic ins;  // write the value at the position, shift the rest toward the tail
    logic deq;  // shift every entry one place toward the head
  } cell_cmd_t;

endpackage

### rtl/qwpi_cell.sv
module qwpi_cell
  import qwpi_pkg::*;
#(
  parameter int unsigned CntW = 5,
  parameter int unsigned Idx = 0
) (
  input  logic                    clk_i,
  input  cell_cmd_t               cmd_i,
  input  logic [CntW-1:0]         pos_i,
  input  logic signed [DataW-1:0] value_i,
  input  logic signed [DataW-1:0] prev_i,
  input  logic signed [DataW-1:0] next_i,
  output logic signed [DataW-1:0] data_o
);

  localparam logic [CntW-1:0] IdxC = CntW'(Idx);

  logic signed [DataW-1:0] data_q;
  logic signed [DataW-1:0] data_d;

  always_comb begin
    data_d = data_q;
    if (cmd_i.deq) begin
      data_d = next_i;
    end else if (cmd_i.ins) begin
      if (IdxC == pos_i) begin
        data_d = value_i;
      end else if (IdxC > pos_i) begin
        data_d = prev_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

### rtl/queue_with_positional_insert.sv
// Bounded queue of signed 32-bit values with enqueue, dequeue and insert at
// a position counted from the head.
// Input stream (s_axis_*): one transfer carries an operation, a value and a
// position. Output stream (m_axis_*): one transfer per input transfer, with
// the dequeued value, a status and the occupancy after the operation.
// The entries sit in a chain of DEPTH cells, cell 0 being the head. Every
// operation that succeeds acts on the chain in the single cycle of acceptance: a
// dequeue shifts every cell toward the head, an insert shifts the cells
// behind the position toward the tail, and an enqueue is an insert at the
// tail.
// The result sits in an output register and is valid in the cycle after the
// input transfer; one item is taken per cycle while the receiver does not stall.
// While the receiver stalls, the result holds in the output register and the
// input is refused until it has been taken.
// Reset empties the queue and drops any pending result; the cells keep old
// contents, which are never read before being written.
module queue_with_positional_insert
  import qwpi_pkg::*;
#(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // operation[1:0], value[33:2], position[38:34], zero fill above
  input  logic [InTdataW-1:0]  s_axis_tdata_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // out_value[31:0], status[33:32], occupancy[38:34], zero fill above
  output logic [OutTdataW-1:0] m_axis_tdata_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned CmpW = (CntW > PosW) ? CntW : PosW;
  localparam logic [CntW-1:0] DepthC = CntW'(DEPTH);

  logic [OpW-1:0]          in_op;
  logic signed [DataW-1:0] in_value;
  logic [PosW-1:0]         in_pos;

  assign in_op    = s_axis_tdata_i[OpW-1:0];
  assign in_value = s_axis_tdata_i[OpW+DataW-1:OpW];
  assign in_pos   = s_axis_tdata_i[OpW+DataW+PosW-1:OpW+DataW];

  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q;
  logic signed [DataW-1:0] out_value_q, out_value_d;
  status_e         status_q, status_d;
  logic [OccW-1:0] occ_q;

  logic            accept;
  logic            full, empty, beyond;
  logic [CmpW-1:0] pos_w, cnt_w, cnt_d_w;
  logic [CntW-1:0] ins_pos;
  cell_cmd_t       cmd;

  logic signed [DataW-1:0] cell_data [DEPTH];

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  assign full   = (count_q == DepthC);
  assign empty  = (count_q == '0);
  assign pos_w  = CmpW'(in_pos);
  assign cnt_w  = CmpW'(count_q);
  assign beyond = (pos_w > cnt_w);

  always_comb begin
    cmd         = '0;
    ins_pos     = count_q;
    status_d    = ST_OK;
    out_value_d = '0;
    count_d     = count_q;
    case (in_op)
      OP_ENQUEUE: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          cmd.ins = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      OP_DEQUEUE: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          cmd.deq     = 1'b1;
          out_value_d = cell_data[0];
          count_d     = count_q - 1'b1;
        end
      end
      OP_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else if (beyond) begin
          status_d = ST_RANGE;
        end else begin
          cmd.ins = 1'b1;
          ins_pos = pos_w[CntW-1:0];
          count_d = count_q + 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (!accept) begin
      cmd     = '0;
      count_d = count_q;
    end
  end

  assign cnt_d_w = CmpW'(count_d);

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [DataW-1:0] prev_data, next_data;
    if (g == 0) begin : g_head
      assign prev_data = in_value;
    end else begin : g_body
      assign prev_data = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign next_data = cell_data[g];
    end else begin : g_inner
      assign next_data = cell_data[g+1];
    end
    qwpi_cell #(
      .CntW (CntW),
      .Idx  (g)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .pos_i   (ins_pos),
      .value_i (in_value),
      .prev_i  (prev_data),
      .next_i  (next_data),
      .data_o  (cell_data[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_value_q <= out_value_d;
      status_q    <= status_d;
      occ_q       <= cnt_d_w[OccW-1:0];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutTdataW'({occ_q, status_q, out_value_q});

endmodule

### rtl/qwpi_checker.sv
`include "queue_with_positional_insert_macros.svh"

module qwpi_checker
  import qwpi_pkg::*;
#(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid_i,
  input logic                 s_axis_tready_o,
  input logic [InTdataW-1:0]  s_axis_tdata_i,
  input logic                 m_axis_tvalid_o,
  input logic                 m_axis_tready_i,
  input logic [OutTdataW-1:0] m_axis_tdata_o
);

  localparam logic [OccW-1:0] DepthOcc = OccW'(DEPTH);

  logic [DataW-1:0]   res_value;
  logic [StatusW-1:0] res_status;
  logic [OccW-1:0]    res_occ;

  assign res_value  = m_axis_tdata_o[DataW-1:0];
  assign res_status = m_axis_tdata_o[DataW+StatusW-1:DataW];
  assign res_occ    = m_axis_tdata_o[DataW+StatusW+OccW-1:DataW+StatusW];

  `QWPI_ASSERT_NEXT(a_result_follows, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o, m_axis_tvalid_o, "accepted item gave no result in the next cycle")
  `QWPI_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o), "stalled result changed")
  `QWPI_ASSERT_SAME(a_error_no_value, clk_i, rst_ni, m_axis_tvalid_o && (res_status != ST_OK), res_value == '0, "failed operation returned a value")
  `QWPI_ASSERT_SAME(a_empty_occ, clk_i, rst_ni, m_axis_tvalid_o && (res_status == ST_EMPTY), res_occ == '0, "empty status with entries held")
  `QWPI_ASSERT_SAME(a_full_occ, clk_i, rst_ni, m_axis_tvalid_o && (res_status == ST_FULL), res_occ == DepthOcc, "full status without a full queue")

endmodule

bind queue_with_positional_insert qwpi_checker #(.DEPTH(DEPTH)) u_qwpi_checker (.*);

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import qwpi_pkg::*;

  localparam int unsigned QDepth = DefaultDepth;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned RandomItems = 900;
  localparam logic [OpW-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [DataW-1:0] value;
    status_e          status;
    logic [OccW-1:0]  occ;
  } queue_result_t;

  // Mirrors the shift chain and holds the results still owed by the block.
  class queue_scoreboard;
    logic [DataW-1:0] cells [QDepth];
    int unsigned      fill;
    int unsigned      errors;
    queue_result_t    pending_results[$];

    function new();
      fill = 0;
      errors = 0;
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    function void apply_operation(logic [OpW-1:0] op, logic [DataW-1:0] val,
                                  logic [PosW-1:0] pos);
      queue_result_t res;
      res.value = '0;
      res.status = ST_OK;
      case (op)
        OP_ENQUEUE: begin
          if (fill >= QDepth) begin
            res.status = ST_FULL;
          end else begin
            cells[fill] = val;
            fill++;
          end
        end
        OP_DEQUEUE: begin
          if (fill == 0) begin
            res.status = ST_EMPTY;
          end else begin
            res.value = cells[0];
            for (int i = 1; i < fill; i++) cells[i-1] = cells[i];
            fill--;
          end
        end
        OP_INSERT: begin
          // A full queue is reported ahead of a bad position.
          if (fill >= QDepth) begin
            res.status = ST_FULL;
          end else if (pos > fill) begin
            res.status = ST_RANGE;
          end else begin
            for (int i = fill; i > pos; i--) cells[i] = cells[i-1];
            cells[pos] = val;
            fill++;
          end
        end
        default: begin
        end
      endcase
      res.occ = fill[OccW-1:0];
      pending_results.push_back(res);
    endfunction

    function void check_result(logic [OutTdataW-1:0] data);
      queue_result_t    want;
      logic [DataW-1:0] got_value;
      logic [StatusW-1:0] got_status;
      logic [OccW-1:0]  got_occ;
      got_value = data[DataW-1:0];
      got_status = data[DataW +: StatusW];
      got_occ = data[DataW+StatusW +: OccW];
      if (pending_results.size() == 0) begin
        errors++;
        $error("result transfer with no operation pending: %h", data);
        return;
      end
      want = pending_results.pop_front();
      if (got_value !== want.value) begin
        errors++;
        $error("out_value: expected %0d, actual %0d", $signed(want.value),
               $signed(got_value));
      end
      if (got_status !== want.status) begin
        errors++;
        $error("status: expected %0d, actual %0d", want.status, got_status);
      end
      if (got_occ !== want.occ) begin
        errors++;
        $error("occupancy: expected %0d, actual %0d", want.occ, got_occ);
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_valid;
  logic                 s_ready;
  logic [InTdataW-1:0]  s_data;
  logic                 m_valid;
  logic                 m_ready = 1'b0;
  logic [OutTdataW-1:0] m_data;

  queue_scoreboard sb = new();
  int unsigned     cycles = 0;
  int unsigned     stall_mode = 0;
  int unsigned     burst_left = 1;

  queue_with_positional_insert #(
    .DEPTH(QDepth)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // The receiver switches now and then between always ready, coin-flip
  // stalls and long stalls.
  always @(posedge clk_i) begin
    if ($urandom_range(63) == 0) stall_mode <= $urandom_range(2);
    case (stall_mode)
      0: m_ready <= 1'b1;
      1: m_ready <= 1'($urandom_range(1));
      default: m_ready <= ($urandom_range(3) == 0);
    endcase
  end

  // A result always belongs to an earlier transfer, so it is checked first.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_valid && m_ready) sb.check_result(m_data);
      if (s_valid && s_ready) begin
        sb.apply_operation(s_data[OpW-1:0], s_data[OpW +: DataW],
                           s_data[OpW+DataW +: PosW]);
      end
    end
  end

  task automatic send_item(input logic [OpW-1:0] op, input logic [DataW-1:0] val,
                           input logic [PosW-1:0] pos);
    s_valid <= 1'b1;
    s_data <= InTdataW'({pos, val, op});
    do @(posedge clk_i); while (!s_ready);
  endtask

  task automatic pace_sender();
    int unsigned gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = $urandom_range(6);
      burst_left = ($urandom_range(3) == 0) ? 120 : $urandom_range(24, 1);
      if (gap != 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic wait_queue_settled();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // The mix leans toward filling, draining, balance or malformed requests.
  task automatic send_random_item(input int unsigned bias);
    logic [DataW-1:0] extremes [4];
    logic [OpW-1:0]   op;
    logic [DataW-1:0] val;
    logic [PosW-1:0]  pos;
    int unsigned      r;
    int unsigned      p;
    extremes = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};
    r = $urandom_range(99);
    case (bias)
      0: op = (r < 45) ? OP_ENQUEUE : (r < 85) ? OP_INSERT : (r < 97) ? OP_DEQUEUE : OP_UNUSED;
      1: op = (r < 20) ? OP_ENQUEUE : (r < 35) ? OP_INSERT : (r < 97) ? OP_DEQUEUE : OP_UNUSED;
      2: op = (r < 30) ? OP_ENQUEUE : (r < 60) ? OP_INSERT : (r < 95) ? OP_DEQUEUE : OP_UNUSED;
      default: op = (r < 20) ? OP_ENQUEUE : (r < 60) ? OP_INSERT : (r < 80) ? OP_DEQUEUE : OP_UNUSED;
    endcase
    p = $urandom_range(9);
    if (bias == 3 || p < 2) pos = PosW'($urandom_range(31));
    else if (p < 4) pos = PosW'(sb.fill);
    else pos = PosW'($urandom_range(sb.fill));
    val = ($urandom_range(9) == 0) ? extremes[$urandom_range(3)] : $urandom();
    send_item(op, val, pos);
  endtask

  initial begin
    int unsigned bias;
    rst_ni = 1'b0;
    s_valid = 1'b0;
    s_data = '0;
    bias = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(OP_DEQUEUE, 32'h0, 5'd0);            // empty queue
    send_item(OP_INSERT, 32'h5, 5'd1);             // position past the end on empty
    send_item(OP_INSERT, 32'h7fff_ffff, 5'd0);     // insert into empty at head
    send_item(OP_ENQUEUE, 32'h8000_0000, 5'd0);
    send_item(OP_INSERT, 32'hffff_ffff, 5'd2);     // insert at count acts as enqueue
    send_item(OP_INSERT, 32'h0, 5'd1);             // insert in the middle
    send_item(OP_INSERT, 32'h1, 5'd31);
    send_item(OP_UNUSED, 32'hffff_ffff, 5'd31);
    send_item(OP_DEQUEUE, 32'h7fff_ffff, 5'd31);
    for (int i = 0; i < 13; i++) send_item(OP_ENQUEUE, $urandom(), 5'd0);
    send_item(OP_ENQUEUE, 32'h1234_5678, 5'd0);    // full queue
    send_item(OP_INSERT, 32'h1, 5'd31);            // full wins over a bad position
    send_item(OP_INSERT, 32'h2, 5'd0);
    send_item(OP_DEQUEUE, 32'h0, 5'd0);
    wait_queue_settled();

    for (int i = 0; i < RandomItems; i++) begin
      if (i % 40 == 0) bias = $urandom_range(3);
      if (i == RandomItems / 2) wait_queue_settled();
      send_random_item(bias);
      pace_sender();
    end
    wait_queue_settled();
    repeat (8) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
